### rtl/assert_macros.svh
// Concurrent assertion helpers; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_SAME_CYCLE(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

`define ASSERT_NEXT_CYCLE(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define ASSERT_SAME_CYCLE(lbl, clk, rst, ante, cons)

`define ASSERT_NEXT_CYCLE(lbl, clk, rst, ante, cons)

`endif

`endif

### rtl/sao_pkg.sv
package sao_pkg;

   localparam int SPR_MAX_W = 64;
   localparam int SPR_MAX_H = 64;
   localparam int SPR_DEPTH = SPR_MAX_W * SPR_MAX_H;
   localparam int SPR_ADDR_W = $clog2(SPR_DEPTH);
   localparam int SPR_ENTRY_W = 32;

   localparam int CHANS = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_BLEND = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPRITE_WIDTH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPRITE_HEIGHT = 2'd3;

   localparam logic [6:0] SPRITE_DIM_RESET = 7'd64;

   // floor(s / 255) for s up to 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] s);
      logic [16:0] t;
      t = 17'(s) + 17'd1 + 17'(s[15:8]);
      return t[15:8];
   endfunction

endpackage

### rtl/sao_ram.sv
module sao_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sprite_alpha_overlay.sv
// A blend beat passes through the stage 1 and result registers to rsp_valid.
// Throughput: one beat per cycle, loads and blends alike, unless rsp_stall holds
// the pipeline; the sprite store read port and the result register each
// take one beat per cycle. Loads write the store at accept; no result beat.
// Reset: synchronous, clears the pipeline and sets offsets to 0 and the
// sprite size to 64x64; the sprite store holds garbage until loaded.
`include "assert_macros.svh"

module sprite_alpha_overlay (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [11:0] req_pos_x,
   input  logic [11:0] req_pos_y,
   input  logic [7:0]  req_chan0,
   input  logic [7:0]  req_chan1,
   input  logic [7:0]  req_chan2,
   input  logic [7:0]  req_alpha,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_blend0,
   output logic [7:0]  rsp_blend1,
   output logic [7:0]  rsp_blend2,
   output logic        rsp_covered,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sao_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sao_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic signed [11:0] offset_x_ff;
   logic signed [11:0] offset_y_ff;
   logic [6:0]         width_ff;
   logic [6:0]         height_ff;

   logic adv1;
   logic adv2;
   logic req_accept;

   logic [6:0]         w_eff;
   logic [6:0]         h_eff;
   logic signed [13:0] fx;
   logic signed [13:0] fy;
   logic               in_win;
   logic [12:0]        col;
   logic [12:0]        row;
   logic [sao_pkg::SPR_ADDR_W-1:0]  spr_addr;
   logic                            spr_wr_en;
   logic [sao_pkg::SPR_ENTRY_W-1:0] spr_wr_data;
   logic [sao_pkg::SPR_ENTRY_W-1:0] spr_rd_data;

   logic       s1_valid_ff;
   logic       s1_inside_ff;
   logic [7:0] s1_bg_ff [sao_pkg::CHANS];

   logic [7:0]  fg_alpha;
   logic        s1_cov;
   logic [15:0] s1_sum [sao_pkg::CHANS];
   logic [7:0]  s1_pix [sao_pkg::CHANS];

   logic       rsp_valid_ff;
   logic       rsp_covered_ff;
   logic [7:0] rsp_pix_ff [sao_pkg::CHANS];

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         width_ff    <= sao_pkg::SPRITE_DIM_RESET;
         height_ff   <= sao_pkg::SPRITE_DIM_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sao_pkg::CSR_OFFSET_X:      offset_x_ff <= csr_wdata;
            sao_pkg::CSR_OFFSET_Y:      offset_y_ff <= csr_wdata;
            sao_pkg::CSR_SPRITE_WIDTH:  width_ff    <= csr_wdata[6:0];
            sao_pkg::CSR_SPRITE_HEIGHT: height_ff   <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // stage advance, back to front
   assign adv2       = !rsp_valid_ff || !rsp_stall;
   assign adv1       = !s1_valid_ff || adv2;
   assign req_stall  = !adv1;
   assign req_accept = req_valid && adv1;

   // window test and store address
   assign w_eff = (32'(width_ff) > sao_pkg::SPR_MAX_W) ? 7'(sao_pkg::SPR_MAX_W) : width_ff;
   assign h_eff = (32'(height_ff) > sao_pkg::SPR_MAX_H) ? 7'(sao_pkg::SPR_MAX_H) : height_ff;

   assign fx = $signed({2'b00, req_pos_x}) - $signed({{2{offset_x_ff[11]}}, offset_x_ff});
   assign fy = $signed({2'b00, req_pos_y}) - $signed({{2{offset_y_ff[11]}}, offset_y_ff});

   assign in_win = !fx[13] && !fy[13] &&
                   (fx[12:0] < 13'(w_eff)) && (fy[12:0] < 13'(h_eff));

   assign col = (req_func == sao_pkg::FUNC_LOAD) ? {1'b0, req_pos_x} : fx[12:0];
   assign row = (req_func == sao_pkg::FUNC_LOAD) ? {1'b0, req_pos_y} : fy[12:0];
   assign spr_addr = sao_pkg::SPR_ADDR_W'(32'(row) * sao_pkg::SPR_MAX_W + 32'(col));

   assign spr_wr_en = req_accept && (req_func == sao_pkg::FUNC_LOAD) &&
                      (32'(req_pos_x) < sao_pkg::SPR_MAX_W) &&
                      (32'(req_pos_y) < sao_pkg::SPR_MAX_H);
   assign spr_wr_data = {req_alpha, req_chan2, req_chan1, req_chan0};

   sao_ram #(
      .WIDTH (sao_pkg::SPR_ENTRY_W),
      .DEPTH (sao_pkg::SPR_DEPTH)
   ) u_sprite_ram (
      .clock   (clock),
      .wr_en   (spr_wr_en),
      .wr_addr (spr_addr),
      .wr_data (spr_wr_data),
      .rd_en   (adv1),
      .rd_addr (spr_addr),
      .rd_data (spr_rd_data)
   );

   // stage 1: store data arrives, form weighted sums
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv1) begin
         s1_valid_ff <= req_accept && (req_func == sao_pkg::FUNC_BLEND);
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_inside_ff <= in_win;
         s1_bg_ff[0]  <= req_chan0;
         s1_bg_ff[1]  <= req_chan1;
         s1_bg_ff[2]  <= req_chan2;
      end
   end

   assign fg_alpha = spr_rd_data[31:24];
   assign s1_cov   = s1_inside_ff && (fg_alpha != 8'd0);

   always_comb begin
      for (int c = 0; c < sao_pkg::CHANS; c++) begin
         s1_sum[c] = 16'(s1_bg_ff[c] * (8'd255 - fg_alpha)) +
                     16'(spr_rd_data[8*c +: 8] * fg_alpha);
      end
   end

   // divide by 255 or pass background
   always_comb begin
      for (int c = 0; c < sao_pkg::CHANS; c++) begin
         s1_pix[c] = s1_cov ? sao_pkg::div255(s1_sum[c]) : s1_bg_ff[c];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv2) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         rsp_covered_ff <= s1_cov;
         for (int c = 0; c < sao_pkg::CHANS; c++) begin
            rsp_pix_ff[c] <= s1_pix[c];
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_blend0  = rsp_pix_ff[0];
   assign rsp_blend1  = rsp_pix_ff[1];
   assign rsp_blend2  = rsp_pix_ff[2];
   assign rsp_covered = rsp_covered_ff;

   `ASSERT_NEXT_CYCLE(a_blend_enters, clock, reset,
      req_valid && !req_stall && (req_func == sao_pkg::FUNC_BLEND), s1_valid_ff)
   `ASSERT_NEXT_CYCLE(a_load_no_beat, clock, reset,
      req_valid && !req_stall && (req_func == sao_pkg::FUNC_LOAD), !s1_valid_ff)
   `ASSERT_NEXT_CYCLE(a_pass_through, clock, reset,
      s1_valid_ff && adv2 && !s1_cov,
      rsp_valid && !rsp_covered && (rsp_blend0 == $past(s1_bg_ff[0])))

endmodule

### test/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_BEATS = 250;

   typedef struct {
      logic        func;
      logic [11:0] x;
      logic [11:0] y;
      logic [7:0]  c0;
      logic [7:0]  c1;
      logic [7:0]  c2;
      logic [7:0]  a;
   } pixel_in_type;

   typedef struct {
      logic [7:0] blend0;
      logic [7:0] blend1;
      logic [7:0] blend2;
      logic       covered;
   } pixel_out_type;

   class overlay_predictor_type;
      logic [11:0]                     off_x;
      logic [11:0]                     off_y;
      logic [6:0]                      win_w;
      logic [6:0]                      win_h;
      logic [sao_pkg::SPR_ENTRY_W-1:0] sprite_mem [sao_pkg::SPR_DEPTH];
      pixel_out_type                   pending_pixels [$];
      int                              mismatches;

      function new();
         off_x = '0;
         off_y = '0;
         win_w = sao_pkg::SPRITE_DIM_RESET;
         win_h = sao_pkg::SPRITE_DIM_RESET;
         mismatches = 0;
         foreach (sprite_mem[i]) sprite_mem[i] = '0;
      endfunction

      function void set_reg(logic [sao_pkg::CSR_IDX_W-1:0] idx,
                            logic [sao_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            sao_pkg::CSR_OFFSET_X: off_x = val;
            sao_pkg::CSR_OFFSET_Y: off_y = val;
            sao_pkg::CSR_SPRITE_WIDTH: win_w = val[6:0];
            sao_pkg::CSR_SPRITE_HEIGHT: win_h = val[6:0];
            default: ;
         endcase
      endfunction

      function int clamp_dim(logic [6:0] v, int limit);
         return (int'(v) > limit) ? limit : int'(v);
      endfunction

      function bit window_hit(logic [11:0] x, logic [11:0] y, output int addr);
         int fx;
         int fy;
         fx = int'(x) - int'($signed(off_x));
         fy = int'(y) - int'($signed(off_y));
         addr = fy * sao_pkg::SPR_MAX_W + fx;
         return fx >= 0 && fy >= 0 && fx < clamp_dim(win_w, sao_pkg::SPR_MAX_W)
            && fy < clamp_dim(win_h, sao_pkg::SPR_MAX_H);
      endfunction

      function logic [7:0] mix(int unsigned bg, int unsigned fg, int unsigned al);
         return 8'((bg * (255 - al) + fg * al) / 255);
      endfunction

      function void note_pixel(pixel_in_type b);
         pixel_out_type                   r;
         int                              addr;
         logic [sao_pkg::SPR_ENTRY_W-1:0] e;
         if (b.func == sao_pkg::FUNC_LOAD) begin
            if (b.x < sao_pkg::SPR_MAX_W && b.y < sao_pkg::SPR_MAX_H)
               sprite_mem[int'(b.y) * sao_pkg::SPR_MAX_W + int'(b.x)] =
                  {b.a, b.c2, b.c1, b.c0};
            return;
         end
         r.blend0 = b.c0;
         r.blend1 = b.c1;
         r.blend2 = b.c2;
         r.covered = 1'b0;
         if (window_hit(b.x, b.y, addr)) begin
            e = sprite_mem[addr];
            if (e[31:24] != 8'd0) begin
               r.blend0 = mix(b.c0, e[7:0], e[31:24]);
               r.blend1 = mix(b.c1, e[15:8], e[31:24]);
               r.blend2 = mix(b.c2, e[23:16], e[31:24]);
               r.covered = 1'b1;
            end
         end
         pending_pixels.push_back(r);
      endfunction

      function void check_pixel(pixel_out_type got);
         pixel_out_type want;
         if (pending_pixels.size() == 0) begin
            $error("result beat with nothing pending");
            mismatches++;
            return;
         end
         want = pending_pixels.pop_front();
         if (got.blend0 !== want.blend0) begin
            $error("blend0 expected %0d actual %0d", want.blend0, got.blend0);
            mismatches++;
         end
         if (got.blend1 !== want.blend1) begin
            $error("blend1 expected %0d actual %0d", want.blend1, got.blend1);
            mismatches++;
         end
         if (got.blend2 !== want.blend2) begin
            $error("blend2 expected %0d actual %0d", want.blend2, got.blend2);
            mismatches++;
         end
         if (got.covered !== want.covered) begin
            $error("covered expected %0d actual %0d", want.covered, got.covered);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = sao_pkg::FUNC_LOAD;
   logic [11:0] req_pos_x = '0;
   logic [11:0] req_pos_y = '0;
   logic [7:0]  req_chan0 = '0;
   logic [7:0]  req_chan1 = '0;
   logic [7:0]  req_chan2 = '0;
   logic [7:0]  req_alpha = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_blend0;
   logic [7:0]  rsp_blend1;
   logic [7:0]  rsp_blend2;
   logic        rsp_covered;

   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [sao_pkg::CSR_IDX_W-1:0]  csr_index = sao_pkg::CSR_OFFSET_X;
   logic [sao_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   overlay_predictor_type blend_pred;
   bit                    loaded [sao_pkg::SPR_DEPTH];
   int                    beats_sent = 0;
   int                    send_idle_pct = 0;
   int                    recv_idle_pct = 0;
   int                    quiet_cycles = 0;

   sprite_alpha_overlay dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_func    (req_func),
      .req_pos_x   (req_pos_x),
      .req_pos_y   (req_pos_y),
      .req_chan0   (req_chan0),
      .req_chan1   (req_chan1),
      .req_chan2   (req_chan2),
      .req_alpha   (req_alpha),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_blend0  (rsp_blend0),
      .rsp_blend1  (rsp_blend1),
      .rsp_blend2  (rsp_blend2),
      .rsp_covered (rsp_covered),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin : rsp_monitor
      pixel_out_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.blend0 = rsp_blend0;
            got.blend1 = rsp_blend1;
            got.blend2 = rsp_blend2;
            got.covered = rsp_covered;
            blend_pred.check_pixel(got);
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_beat(input pixel_in_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= b.func;
      req_pos_x <= b.x;
      req_pos_y <= b.y;
      req_chan0 <= b.c0;
      req_chan1 <= b.c1;
      req_chan2 <= b.c2;
      req_alpha <= b.a;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      blend_pred.note_pixel(b);
      if (b.func == sao_pkg::FUNC_BLEND ||
          (b.x < sao_pkg::SPR_MAX_W && b.y < sao_pkg::SPR_MAX_H)) beats_sent++;
   endtask

   function automatic logic [7:0] pick_alpha();
      case ($urandom_range(6))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic load_px(input logic [11:0] x, input logic [11:0] y, input logic [7:0] c0,
                          input logic [7:0] c1, input logic [7:0] c2, input logic [7:0] a);
      pixel_in_type b;
      b = '{sao_pkg::FUNC_LOAD, x, y, c0, c1, c2, a};
      if (x < sao_pkg::SPR_MAX_W && y < sao_pkg::SPR_MAX_H)
         loaded[int'(y) * sao_pkg::SPR_MAX_W + int'(x)] = 1'b1;
      send_beat(b);
   endtask

   // back-fill any sprite entry the blend would read before it was ever loaded
   task automatic blend_px(input logic [11:0] x, input logic [11:0] y, input logic [7:0] c0,
                           input logic [7:0] c1, input logic [7:0] c2);
      pixel_in_type b;
      int           addr;
      if (blend_pred.window_hit(x, y, addr) && !loaded[addr])
         load_px(12'(addr % sao_pkg::SPR_MAX_W), 12'(addr / sao_pkg::SPR_MAX_W),
                 8'($urandom), 8'($urandom), 8'($urandom), pick_alpha());
      b = '{sao_pkg::FUNC_BLEND, x, y, c0, c1, c2, 8'($urandom)};
      send_beat(b);
   endtask

   task automatic pause_stream();
      req_valid <= 1'b0;
      while (blend_pred.pending_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [sao_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sao_pkg::CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      blend_pred.set_reg(idx, val);
   endtask

   task automatic program_window(input logic [11:0] ox, input logic [11:0] oy,
                                 input logic [11:0] w, input logic [11:0] h);
      pause_stream();
      repeat (4) @(posedge clock);
      write_csr(sao_pkg::CSR_OFFSET_X, ox);
      write_csr(sao_pkg::CSR_OFFSET_Y, oy);
      write_csr(sao_pkg::CSR_SPRITE_WIDTH, w);
      write_csr(sao_pkg::CSR_SPRITE_HEIGHT, h);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [11:0] pick_offset();
      case ($urandom_range(3))
         0, 1: return 12'(int'($urandom_range(140)) - 70);
         2: return 12'($urandom);
         default: return 12'(2047 - int'($urandom_range(64)));
      endcase
   endfunction

   function automatic logic [11:0] pick_dim();
      logic [6:0] d;
      if ($urandom_range(7) == 0) d = 7'($urandom_range(127));
      else d = 7'($urandom_range(64, 1));
      return {5'($urandom), d};
   endfunction

   task automatic random_beat();
      logic [11:0] x;
      logic [11:0] y;
      int          w;
      int          h;
      if ($urandom_range(99) < 25) begin
         if ($urandom_range(9) == 0) begin
            x = 12'($urandom);
            y = 12'($urandom);
         end else begin
            x = 12'($urandom_range(sao_pkg::SPR_MAX_W - 1));
            y = 12'($urandom_range(sao_pkg::SPR_MAX_H - 1));
         end
         load_px(x, y, 8'($urandom), 8'($urandom), 8'($urandom), pick_alpha());
      end else begin
         if ($urandom_range(9) < 8) begin
            w = blend_pred.clamp_dim(blend_pred.win_w, sao_pkg::SPR_MAX_W);
            h = blend_pred.clamp_dim(blend_pred.win_h, sao_pkg::SPR_MAX_H);
            x = 12'(int'(blend_pred.off_x) + int'($urandom_range(w + 5)) - 3);
            y = 12'(int'(blend_pred.off_y) + int'($urandom_range(h + 5)) - 3);
         end else begin
            x = 12'($urandom);
            y = 12'($urandom);
         end
         blend_px(x, y, 8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      int target;
      blend_pred = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      load_px(0, 0, 255, 0, 128, 255);
      load_px(63, 63, 1, 2, 3, 0);
      load_px(63, 0, 200, 100, 50, 1);
      load_px(0, 63, 17, 34, 51, 128);
      load_px(64, 0, 9, 9, 9, 9);
      load_px(0, 64, 9, 9, 9, 9);
      load_px(4095, 4095, 255, 255, 255, 255);
      blend_px(0, 0, 0, 255, 127);
      blend_px(63, 63, 9, 8, 7);
      blend_px(63, 0, 255, 255, 255);
      blend_px(0, 63, 0, 0, 0);
      blend_px(64, 0, 1, 2, 3);
      blend_px(0, 64, 1, 2, 3);
      blend_px(4095, 4095, 255, 255, 255);
      load_px(5, 5, 10, 20, 30, 200);
      blend_px(5, 5, 250, 240, 230);
      load_px(5, 5, 1, 1, 1, 0);
      blend_px(5, 5, 4, 5, 6);

      program_window(12'h800, 12'h7FF, 12'd127, 12'd1);
      blend_px(4095, 2047, 33, 66, 99);
      program_window(12'h7FF, 12'hFFF, 12'hF80, 12'd64);
      blend_px(2047, 0, 12, 34, 56);
      program_window(12'h7FF, 12'h7FF, 12'hFC0, 12'd64);
      blend_px(2047, 2047, 100, 150, 200);
      blend_px(2110, 2110, 7, 77, 177);
      blend_px(2046, 2047, 1, 1, 1);
      program_window(12'hFFF, 12'hFC1, 12'd64, 12'd0);
      blend_px(0, 0, 60, 70, 80);
      program_window(12'hFFF, 12'hFC1, 12'd64, 12'd64);
      blend_px(0, 0, 90, 45, 15);

      for (int ph = 0; ph < 6; ph++) begin
         program_window(pick_offset(), pick_offset(), pick_dim(), pick_dim());
         send_idle_pct = (ph < 2) ? 23 : (ph < 4) ? 60 : 0;
         recv_idle_pct = (ph < 2) ? 60 : (ph < 4) ? 23 : 0;
         target = beats_sent + PHASE_BEATS;
         while (beats_sent < target) begin
            random_beat();
            if ($urandom_range(199) == 0) pause_stream();
         end
      end

      pause_stream();
      repeat (10) @(posedge clock);
      if (blend_pred.mismatches == 0 && blend_pred.pending_pixels.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

### sprite_alpha_overlay.f
+incdir+rtl
rtl/sao_pkg.sv
rtl/sao_ram.sv
rtl/sprite_alpha_overlay.sv
test/tb_top.sv
